@@ rtl/core/hnorm_pkg.sv @@
// Shared types and constants for the height-field normal generator.
// No dependencies; imported by every module in rtl/core.
package hnorm_pkg;

    localparam int GRID_SIZE   = 16;
    localparam int HEIGHT_BITS = 16;
    localparam int COL_W       = $clog2(GRID_SIZE);
    localparam int ADDR_W      = $clog2(2 * GRID_SIZE);
    localparam int CELL_W      = 4;
    localparam int SCALE_W     = 24;
    localparam int AX_W        = HEIGHT_BITS + SCALE_W;
    localparam int MUL_W       = 30;
    localparam int SUM_W       = 63;
    localparam int LEN_W       = 31;
    localparam int NUM_W       = 46;
    localparam int Q_W         = 16;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(200);
    localparam logic [COL_W-1:0]   LAST_POS    = COL_W'(GRID_SIZE - 1);
    localparam logic [AX_W-1:0]    AY_INIT     = AX_W'(2 << 16);

    typedef struct packed {
        logic [HEIGHT_BITS-1:0] pr;
        logic [HEIGHT_BITS-1:0] nr;
        logic [HEIGHT_BITS-1:0] pc;
        logic [HEIGHT_BITS-1:0] nc;
        logic [CELL_W-1:0]      row;
        logic [CELL_W-1:0]      col;
        logic                   last;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MULX,
        B_MULZ,
        B_NORM,
        B_SQX,
        B_SQY,
        B_SQZ,
        B_SQRT,
        B_LEN,
        B_DSET,
        B_DIV,
        B_DFIN,
        B_OUT
    } back_state_t;

    function automatic logic [ADDR_W-1:0] slot(input logic par, input logic [COL_W-1:0] col);
        slot = ADDR_W'(col) + (par ? ADDR_W'(GRID_SIZE) : ADDR_W'(0));
    endfunction

endpackage

@@ rtl/core/heightfield_normal_generator.sv @@
// Top level of the height-field normal generator.
// Depends on hnorm_pkg, hnorm_front, hnorm_fifo, hnorm_back.
//
//  channel   signals                         direction
//  input     in_valid/in_ready, height       word in
//  output    out_valid/out_ready, normal_*   word out
//  config    cfg_we, cfg_wdata               height_scale write
//
// Front: a word of row 0 is only stored; other words go through line store
// reads and a push, and the last word also flushes the final row cell by
// cell. Back: one normal at a time, by the 32-step square root and three
// 16-step serial divisions. rst_n clears control state and height_scale to
// 200. Either side stalls independently through the two-entry job queue.
module heightfield_normal_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [15:0]                    height,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [15:0]             normal_x,
    output logic [14:0]                    normal_y,
    output logic signed [15:0]             normal_z,
    output logic [3:0]                     cell_row,
    output logic [3:0]                     cell_column,
    output logic                           last_of_frame,
    input  logic                           cfg_we,
    input  logic [hnorm_pkg::SCALE_W-1:0]  cfg_wdata
);
    import hnorm_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic               push, pop, full, empty;
    job_t               push_job, pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    hnorm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .height    (height),
        .push      (push),
        .push_job  (push_job),
        .fifo_full (full)
    );

    hnorm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    hnorm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_empty    (empty),
        .pop           (pop),
        .job           (pop_job),
        .height_scale  (scale_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .cell_row      (cell_row),
        .cell_column   (cell_column),
        .last_of_frame (last_of_frame)
    );

endmodule

@@ rtl/core/hnorm_fifo.sv @@
// Two-entry job queue between the front and the back.
// Depends on hnorm_pkg (job_t).
module hnorm_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hnorm_pkg::job_t   push_job,
    output logic              full,
    input  logic              pop,
    output hnorm_pkg::job_t   pop_job,
    output logic              empty
);
    import hnorm_pkg::*;

    job_t       q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/core/hnorm_front.sv @@
// Front end: takes height words, keeps two rows in a line store, gathers
// neighbors and queues one job per normal. Depends on hnorm_pkg.
module hnorm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [15:0]                       height,
    output logic                              push,
    output hnorm_pkg::job_t                   push_job,
    input  logic                              fifo_full
);
    import hnorm_pkg::*;

    logic [HEIGHT_BITS-1:0] row_store [2*GRID_SIZE];
    logic [HEIGHT_BITS-1:0] rd_data_reg;

    front_state_t state_reg, state_next;
    logic [COL_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] tgt_row_reg, tgt_row_next;
    logic [COL_W-1:0] tgt_col_reg, tgt_col_next;
    logic             flush_reg, flush_next;
    logic [2:0]       ph_reg, ph_next;

    logic [COL_W-1:0]       cur_row_reg;
    logic [COL_W-1:0]       cur_col_reg;
    logic                   end_reg;
    logic [HEIGHT_BITS-1:0] h_reg;
    logic [HEIGHT_BITS-1:0] centre_reg, up_reg, left_reg, right_reg;

    logic                   accept;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [HEIGHT_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]      rd_addr;

    assign accept = in_ready && in_valid;

    // next state
    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        tgt_row_next = tgt_row_reg;
        tgt_col_next = tgt_col_reg;
        flush_next   = flush_reg;
        ph_next      = ph_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    if (col_reg == LAST_POS)
                    begin
                        col_next = '0;
                        row_next = (row_reg == LAST_POS) ? '0 : row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    if (row_reg != '0)
                    begin
                        tgt_row_next = row_reg - 1'b1;
                        tgt_col_next = col_reg;
                        flush_next   = 1'b0;
                        ph_next      = '0;
                        state_next   = F_READ;
                    end
                end
            end
            F_READ:
            begin
                ph_next = ph_reg + 3'd1;
                if (ph_reg == 3'd4)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!fifo_full)
                begin
                    ph_next = '0;
                    if (!flush_reg)
                    begin
                        if (end_reg)
                        begin
                            flush_next   = 1'b1;
                            tgt_row_next = cur_row_reg;
                            tgt_col_next = '0;
                            state_next   = F_READ;
                        end
                        else
                        begin
                            state_next = F_IDLE;
                        end
                    end
                    else if (tgt_col_reg == LAST_POS)
                    begin
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        tgt_col_next = tgt_col_reg + 1'b1;
                        state_next   = F_READ;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        push      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = slot(cur_row_reg[0], cur_col_reg);
        mem_wdata = h_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && row_reg == '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = slot(row_reg[0], col_reg);
                    mem_wdata = height[HEIGHT_BITS-1:0];
                end
            end
            F_READ:
            begin
            end
            F_PUSH:
            begin
                push   = !fifo_full;
                mem_we = !fifo_full && !flush_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (ph_reg[1:0])
            2'd0:    rd_addr = slot(tgt_row_reg[0], tgt_col_reg);
            2'd1:    rd_addr = slot(~tgt_row_reg[0], tgt_col_reg);
            2'd2:    rd_addr = slot(tgt_row_reg[0], tgt_col_reg - 1'b1);
            default: rd_addr = slot(tgt_row_reg[0], tgt_col_reg + 1'b1);
        endcase
    end

    always_comb
    begin
        push_job.pr   = (tgt_row_reg == '0) ? centre_reg : up_reg;
        push_job.nr   = flush_reg ? centre_reg : h_reg;
        push_job.pc   = (tgt_col_reg == '0) ? centre_reg : left_reg;
        push_job.nc   = (tgt_col_reg == LAST_POS) ? centre_reg : right_reg;
        push_job.row  = CELL_W'(tgt_row_reg);
        push_job.col  = CELL_W'(tgt_col_reg);
        push_job.last = flush_reg && (tgt_col_reg == LAST_POS);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_store[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= row_store[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_reg       <= height[HEIGHT_BITS-1:0];
            cur_row_reg <= row_reg;
            cur_col_reg <= col_reg;
            end_reg     <= (row_reg == LAST_POS) && (col_reg == LAST_POS);
        end
        if (state_reg == F_READ)
        begin
            unique case (ph_reg)
                3'd1:    centre_reg <= rd_data_reg;
                3'd2:    up_reg     <= rd_data_reg;
                3'd3:    left_reg   <= rd_data_reg;
                3'd4:    right_reg  <= rd_data_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            tgt_row_reg <= '0;
            tgt_col_reg <= '0;
            flush_reg   <= 1'b0;
            ph_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            tgt_row_reg <= tgt_row_next;
            tgt_col_reg <= tgt_col_next;
            flush_reg   <= flush_next;
            ph_reg      <= ph_next;
        end
    end

endmodule

@@ rtl/core/hnorm_back.sv @@
// Back end: scales differences, normalizes by an iterative square root and
// three serial divisions, holds the result word. Depends on hnorm_pkg.
module hnorm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fifo_empty,
    output logic                              pop,
    input  hnorm_pkg::job_t                   job,
    input  logic [hnorm_pkg::SCALE_W-1:0]     height_scale,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [15:0]                normal_x,
    output logic [14:0]                       normal_y,
    output logic signed [15:0]                normal_z,
    output logic [3:0]                        cell_row,
    output logic [3:0]                        cell_column,
    output logic                              last_of_frame
);
    import hnorm_pkg::*;

    back_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] comp_reg, comp_next;

    logic                   sx_reg, sz_reg;
    logic [HEIGHT_BITS-1:0] dx_reg, dz_reg;
    logic [AX_W-1:0]        ax_reg, ay_reg, az_reg;
    logic [SUM_W-1:0]       v_reg, res_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       rem_reg;
    logic [15:0]            lo_reg;
    logic [Q_W-1:0]         q_reg;
    logic [15:0]            nx_reg, nz_reg;
    logic [14:0]            ny_reg;
    logic [CELL_W-1:0]      row_reg, col_reg;
    logic                   last_reg;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod;
    logic               big;
    logic [5:0]         sh;
    logic [SUM_W-1:0]   bitv, trial_s;
    logic [MUL_W-1:0]   mag;
    logic               neg;
    logic [NUM_W-1:0]   num;
    logic [LEN_W:0]     trial_d;
    logic [Q_W-1:0]     sat;

    assign big     = |{ax_reg[AX_W-1:MUL_W], ay_reg[AX_W-1:MUL_W], az_reg[AX_W-1:MUL_W]};
    assign sh      = 6'd62 - {cnt_reg, 1'b0};
    assign bitv    = SUM_W'(1) << sh;
    assign trial_s = res_reg + bitv;
    assign trial_d = {rem_reg, lo_reg[15]};
    assign num     = {1'b0, mag, 15'd0} + NUM_W'(len_reg >> 1);
    assign prod    = mul_a * mul_b;

    always_comb
    begin
        unique case (state_reg)
            B_MULX:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(height_scale);
            end
            B_MULZ:
            begin
                mul_a = MUL_W'(dz_reg);
                mul_b = MUL_W'(height_scale);
            end
            B_SQY:
            begin
                mul_a = ay_reg[MUL_W-1:0];
                mul_b = ay_reg[MUL_W-1:0];
            end
            B_SQZ:
            begin
                mul_a = az_reg[MUL_W-1:0];
                mul_b = az_reg[MUL_W-1:0];
            end
            default:
            begin
                mul_a = ax_reg[MUL_W-1:0];
                mul_b = ax_reg[MUL_W-1:0];
            end
        endcase
    end

    always_comb
    begin
        unique case (comp_reg)
            2'd0:
            begin
                mag = ax_reg[MUL_W-1:0];
                neg = sx_reg;
            end
            2'd1:
            begin
                mag = ay_reg[MUL_W-1:0];
                neg = 1'b0;
            end
            default:
            begin
                mag = az_reg[MUL_W-1:0];
                neg = sz_reg;
            end
        endcase
        if (neg)
        begin
            sat = 16'd0 - ((q_reg > 16'd32768) ? 16'd32768 : q_reg);
        end
        else
        begin
            sat = (q_reg > 16'd32767) ? 16'd32767 : q_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        comp_next  = comp_reg;
        unique case (state_reg)
            B_IDLE: if (!fifo_empty) state_next = B_MULX;
            B_MULX: state_next = B_MULZ;
            B_MULZ: state_next = B_NORM;
            B_NORM: if (!big) state_next = B_SQX;
            B_SQX:  state_next = B_SQY;
            B_SQY:  state_next = B_SQZ;
            B_SQZ:
            begin
                cnt_next   = '0;
                state_next = B_SQRT;
            end
            B_SQRT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = B_LEN;
                end
            end
            B_LEN:
            begin
                comp_next  = '0;
                state_next = B_DSET;
            end
            B_DSET:
            begin
                step_next  = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    state_next = B_DFIN;
                end
            end
            B_DFIN:
            begin
                if (comp_reg == 2'd2)
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = B_DSET;
                end
            end
            B_OUT:  if (out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop       = (state_reg == B_IDLE) && !fifo_empty;
        out_valid = (state_reg == B_OUT);
    end

    assign normal_x      = nx_reg;
    assign normal_y      = ny_reg;
    assign normal_z      = nz_reg;
    assign cell_row      = row_reg;
    assign cell_column   = col_reg;
    assign last_of_frame = last_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    sx_reg   <= job.nr < job.pr;
                    dx_reg   <= (job.nr < job.pr) ? job.pr - job.nr : job.nr - job.pr;
                    sz_reg   <= job.nc < job.pc;
                    dz_reg   <= (job.nc < job.pc) ? job.pc - job.nc : job.nc - job.pc;
                    ay_reg   <= AY_INIT;
                    row_reg  <= job.row;
                    col_reg  <= job.col;
                    last_reg <= job.last;
                end
            end
            B_MULX: ax_reg <= prod[AX_W-1:0];
            B_MULZ: az_reg <= prod[AX_W-1:0];
            B_NORM:
            begin
                if (big)
                begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                    az_reg <= az_reg >> 1;
                end
            end
            B_SQX: v_reg <= SUM_W'(prod);
            B_SQY: v_reg <= v_reg + SUM_W'(prod);
            B_SQZ:
            begin
                v_reg   <= v_reg + SUM_W'(prod);
                res_reg <= '0;
            end
            B_SQRT:
            begin
                if (v_reg >= trial_s)
                begin
                    v_reg   <= v_reg - trial_s;
                    res_reg <= (res_reg >> 1) + bitv;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
            end
            B_LEN: len_reg <= (res_reg == '0) ? LEN_W'(1) : res_reg[LEN_W-1:0];
            B_DSET:
            begin
                rem_reg <= LEN_W'(num[NUM_W-1:16]);
                lo_reg  <= num[15:0];
                q_reg   <= '0;
            end
            B_DIV:
            begin
                lo_reg <= {lo_reg[14:0], 1'b0};
                if (trial_d >= {1'b0, len_reg})
                begin
                    rem_reg <= LEN_W'(trial_d - {1'b0, len_reg});
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial_d[LEN_W-1:0];
                    q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                end
            end
            B_DFIN:
            begin
                unique case (comp_reg)
                    2'd0:    nx_reg <= sat;
                    2'd1:    ny_reg <= sat[14:0];
                    default: nz_reg <= sat;
                endcase
            end
            B_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            comp_reg  <= comp_next;
        end
    end

    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SQX) |-> !big)
        else $error("components not below 2^30 at squaring");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (len_reg != '0))
        else $error("zero divisor");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (rem_reg < len_reg))
        else $error("division remainder out of range");

endmodule
